/* rtl/color_gradient_lookup_assert.svh */
// assertion macros for the colour gradient lookup
// used by the top level only, no other dependencies
`ifndef COLOR_GRADIENT_LOOKUP_ASSERT_SVH
`define COLOR_GRADIENT_LOOKUP_ASSERT_SVH

// same-cycle implication under synchronous reset
`define CGL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("colour gradient lookup check failed");

// implication after a fixed number of cycles
`define CGL_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
        else $error("colour gradient lookup latency check failed");

`endif

/* rtl/cgl_pkg.sv */
// shared types, constants and helper functions of the colour gradient lookup
// no dependencies
`default_nettype none

package cgl_pkg;

    localparam int MAX_POINTS         = 6;
    localparam int CNT_W              = 3;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 64;
    localparam int CHAN_W             = 16;
    localparam int OUT_W              = 8;
    localparam int NUM_CH             = 3;
    localparam int DIV_STAGES         = 4;
    localparam int DIV_BITS_PER_STAGE = CHAN_W / DIV_STAGES;
    localparam int CGL_LATENCY        = DIV_STAGES + 5;
    localparam int COUNT_RESET        = 5;
    localparam int SCALE_MUL          = 255;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_POINT0 = 3'd1;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef t_chan [NUM_CH-1:0] t_rgb;

    typedef struct packed {
        t_chan pos;
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_point;

    typedef struct packed {
        logic              valid;
        t_rgb              cur;
        logic [NUM_CH-1:0] neg;
        t_chan             den;
        t_rgb              rem;
        t_rgb              lo;
        t_rgb              quo;
    } t_div_bus;

    typedef struct packed {
        logic  qbit;
        t_chan rem;
    } t_step;

    function automatic t_point point_reset(input int idx);
        t_point p;
        unique case (idx)
            0:       p = 64'h0000_0000_0000_FFFF;
            1:       p = 64'h4000_0000_FFFF_FFFF;
            2:       p = 64'h8000_0000_FFFF_0000;
            3:       p = 64'hBFFF_FFFF_FFFF_0000;
            4:       p = 64'hFFFF_FFFF_0000_0000;
            default: p = '0;
        endcase
        return p;
    endfunction

    // one restoring division step
    function automatic t_step div_step(input t_chan rem, input logic din, input t_chan den);
        logic [CHAN_W:0] t;
        t_step           s;
        t = {rem, din};
        if (t >= {1'b0, den}) begin
            s.qbit = 1'b1;
            s.rem  = CHAN_W'(t - {1'b0, den});
        end else begin
            s.qbit = 1'b0;
            s.rem  = t[CHAN_W-1:0];
        end
        return s;
    endfunction

    // floor(c * 255 / 65535) as ((c + 1) * 255) >> 16
    function automatic logic [OUT_W-1:0] to8(input t_chan c);
        logic [CHAN_W+OUT_W:0] sc;
        sc = (CHAN_W+OUT_W+1)'({1'b0, c} + (CHAN_W+1)'(1)) * (CHAN_W+OUT_W+1)'(SCALE_MUL);
        return sc[CHAN_W+OUT_W-1:CHAN_W];
    endfunction

endpackage

`default_nettype wire

/* rtl/cgl_cfg.sv */
// configuration registers: point count and gradient points
// depends on cgl_pkg
`default_nettype none

module cgl_cfg (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [cgl_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [cgl_pkg::CFG_DATA_W-1:0]           i_cfg_wdata,
    output logic [cgl_pkg::CNT_W-1:0]                o_count,
    output cgl_pkg::t_point [cgl_pkg::MAX_POINTS-1:0] o_points
);
    import cgl_pkg::*;

    logic [CNT_W-1:0]           r_count, n_count;
    t_point [MAX_POINTS-1:0]    r_points, n_points;

    always_comb begin
        n_count  = r_count;
        n_points = r_points;
        if (i_cfg_we) begin
            if (i_cfg_index == CFG_IDX_COUNT) begin
                n_count = i_cfg_wdata[CNT_W-1:0];
            end
            for (int i = 0; i < MAX_POINTS; i++) begin
                if (i_cfg_index == CFG_IDX_W'(int'(CFG_IDX_POINT0) + i)) begin
                    n_points[i] = i_cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(COUNT_RESET);
            for (int i = 0; i < MAX_POINTS; i++) begin
                r_points[i] <= point_reset(i);
            end
        end else begin
            r_count  <= n_count;
            r_points <= n_points;
        end
    end

    assign o_count  = r_count;
    assign o_points = r_points;

endmodule

`default_nettype wire

/* rtl/cgl_seg.sv */
// segment search, operand preparation and product stages
// depends on cgl_pkg
`default_nettype none

module cgl_seg (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  logic [cgl_pkg::CHAN_W-1:0]               i_position,
    input  logic [cgl_pkg::CNT_W-1:0]                i_count,
    input  cgl_pkg::t_point [cgl_pkg::MAX_POINTS-1:0] i_points,
    output cgl_pkg::t_div_bus                        o_div
);
    import cgl_pkg::*;

    // stage 1: find segment
    logic [CNT_W-1:0]      n_cnt;
    logic [MAX_POINTS-1:0] lt, first, last, cur_oh, prev_oh;
    logic                  found;
    t_point                n_s1_cur, n_s1_prev;

    logic   r_s1_valid;
    logic   r_s1_interp;
    t_chan  r_s1_x;
    t_point r_s1_cur, r_s1_prev;

    always_comb begin : p_search
        logic seen;
        n_cnt = (i_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : i_count;
        seen  = 1'b0;
        for (int i = 0; i < MAX_POINTS; i++) begin
            lt[i]    = (CNT_W'(i) < n_cnt) && (i_position < i_points[i].pos);
            first[i] = lt[i] & ~seen;
            seen     = seen | lt[i];
            last[i]  = (n_cnt == CNT_W'(i + 1));
        end
        found  = seen;
        cur_oh = found ? first : last;
        for (int i = 0; i < MAX_POINTS - 1; i++) begin
            prev_oh[i] = first[i+1];
        end
        prev_oh[MAX_POINTS-1] = 1'b0;
        n_s1_cur  = '0;
        n_s1_prev = '0;
        for (int i = 0; i < MAX_POINTS; i++) begin
            n_s1_cur  = n_s1_cur  | ({$bits(t_point){cur_oh[i]}}  & i_points[i]);
            n_s1_prev = n_s1_prev | ({$bits(t_point){prev_oh[i]}} & i_points[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_valid;
            r_s1_interp <= found & ~first[0];
            r_s1_x      <= i_position;
            r_s1_cur    <= n_s1_cur;
            r_s1_prev   <= n_s1_prev;
        end
    end

    // stage 2: differences
    t_rgb              cur_rgb, prev_rgb, n_s2_mag;
    logic [NUM_CH-1:0] n_s2_neg;

    logic              r_s2_valid;
    t_rgb              r_s2_cur, r_s2_mag;
    logic [NUM_CH-1:0] r_s2_neg;
    t_chan             r_s2_num, r_s2_den;

    always_comb begin
        cur_rgb[CH_RED]    = r_s1_cur.red;
        cur_rgb[CH_GREEN]  = r_s1_cur.green;
        cur_rgb[CH_BLUE]   = r_s1_cur.blue;
        prev_rgb[CH_RED]   = r_s1_prev.red;
        prev_rgb[CH_GREEN] = r_s1_prev.green;
        prev_rgb[CH_BLUE]  = r_s1_prev.blue;
        for (int c = 0; c < NUM_CH; c++) begin
            n_s2_neg[c] = prev_rgb[c] < cur_rgb[c];
            if (!r_s1_interp) begin
                n_s2_mag[c] = '0;
            end else if (n_s2_neg[c]) begin
                n_s2_mag[c] = cur_rgb[c] - prev_rgb[c];
            end else begin
                n_s2_mag[c] = prev_rgb[c] - cur_rgb[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
            r_s2_cur   <= cur_rgb;
            r_s2_mag   <= n_s2_mag;
            r_s2_neg   <= n_s2_neg;
            r_s2_num   <= r_s1_cur.pos - r_s1_x;
            r_s2_den   <= r_s1_interp ? (r_s1_cur.pos - r_s1_prev.pos) : CHAN_W'(1);
        end
    end

    // stage 3: products
    t_div_bus                  n_s3;
    logic [2*CHAN_W-1:0]       prod [NUM_CH];
    t_div_bus                  r_s3;

    always_comb begin
        n_s3.valid = r_s2_valid;
        n_s3.cur   = r_s2_cur;
        n_s3.neg   = r_s2_neg;
        n_s3.den   = r_s2_den;
        for (int c = 0; c < NUM_CH; c++) begin
            prod[c]       = (2*CHAN_W)'(r_s2_mag[c]) * (2*CHAN_W)'(r_s2_num);
            n_s3.rem[c]   = prod[c][2*CHAN_W-1:CHAN_W];
            n_s3.lo[c]    = prod[c][CHAN_W-1:0];
            n_s3.quo[c]   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else begin
            r_s3 <= n_s3;
        end
    end

    assign o_div = r_s3;

endmodule

`default_nettype wire

/* rtl/cgl_div.sv */
// one stage of the pipelined restoring divider, several quotient bits per stage
// depends on cgl_pkg
`default_nettype none

module cgl_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cgl_pkg::t_div_bus i_div,
    output cgl_pkg::t_div_bus o_div
);
    import cgl_pkg::*;

    t_div_bus n_div, r_div;

    always_comb begin : p_step
        t_step s;
        n_div = i_div;
        for (int c = 0; c < NUM_CH; c++) begin
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
                s             = div_step(n_div.rem[c], n_div.lo[c][CHAN_W-1], n_div.den);
                n_div.rem[c]  = s.rem;
                n_div.lo[c]   = {n_div.lo[c][CHAN_W-2:0], 1'b0};
                n_div.quo[c]  = {n_div.quo[c][CHAN_W-2:0], s.qbit};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.valid <= 1'b0;
        end else begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

`default_nettype wire

/* rtl/color_gradient_lookup.sv */
// top level of the colour gradient lookup: registers, pipeline, output scaling
// depends on cgl_pkg, cgl_cfg, cgl_seg, cgl_div and color_gradient_lookup_assert.svh
//
// Maps a 16-bit position to an 8-bit RGB colour by linear interpolation between up
// to six programmed gradient points. One position is taken per clock: a transfer
// happens when start is high and busy is low, and busy is only high while in reset
// and for the first cycle after it. The result appears on o_out_red/green/blue with
// o_strobe high for one cycle, in input order; the receiver must take it then. The
// datapath is a nine-stage pipeline: segment search, difference, multiply, four
// divider stages of four quotient bits each, channel reconstruction and 8-bit
// scaling. Configuration writes take effect at once and must only be made while
// no result is outstanding.
`default_nettype none
`include "color_gradient_lookup_assert.svh"

module color_gradient_lookup (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [cgl_pkg::CHAN_W-1:0]     i_position,
    input  logic                           i_cfg_we,
    input  logic [cgl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cgl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                           o_strobe,
    output logic [cgl_pkg::OUT_W-1:0]      o_out_red,
    output logic [cgl_pkg::OUT_W-1:0]      o_out_green,
    output logic [cgl_pkg::OUT_W-1:0]      o_out_blue
);
    import cgl_pkg::*;

    logic                    r_busy;
    logic                    accept;
    logic [CNT_W-1:0]        cfg_count;
    t_point [MAX_POINTS-1:0] cfg_points;
    t_div_bus                w_div [DIV_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start & ~r_busy;

    cgl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_count     (cfg_count),
        .o_points    (cfg_points)
    );

    cgl_seg u_seg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_position (i_position),
        .i_count    (cfg_count),
        .i_points   (cfg_points),
        .o_div      (w_div[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        cgl_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_div   (w_div[g]),
            .o_div   (w_div[g+1])
        );
    end

    // channel reconstruction
    t_rgb n_chan, r_chan;
    logic r_chan_valid;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (w_div[DIV_STAGES].neg[c]) begin
                n_chan[c] = w_div[DIV_STAGES].cur[c] - w_div[DIV_STAGES].quo[c];
            end else begin
                n_chan[c] = w_div[DIV_STAGES].cur[c] + w_div[DIV_STAGES].quo[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_valid <= 1'b0;
        end else begin
            r_chan_valid <= w_div[DIV_STAGES].valid;
            r_chan       <= n_chan;
        end
    end

    // 8-bit scaling and output registers
    logic             r_strobe;
    logic [OUT_W-1:0] r_red, r_green, r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_chan_valid;
            r_red    <= to8(r_chan[CH_RED]);
            r_green  <= to8(r_chan[CH_GREEN]);
            r_blue   <= to8(r_chan[CH_BLUE]);
        end
    end

    assign o_strobe    = r_strobe;
    assign o_out_red   = r_red;
    assign o_out_green = r_green;
    assign o_out_blue  = r_blue;

    `CGL_ASSERT_DELAY(a_result_follows, i_clk, i_rst_n, start && !busy, CGL_LATENCY, o_strobe)
    `CGL_ASSERT_IMPL(a_no_spurious_result, i_clk, i_rst_n, o_strobe, $past(start && !busy, CGL_LATENCY))
    `CGL_ASSERT_IMPL(a_div_remainder_bound, i_clk, i_rst_n, w_div[DIV_STAGES].valid, w_div[DIV_STAGES].rem[CH_RED] < w_div[DIV_STAGES].den || w_div[DIV_STAGES].den == '0)

endmodule

`default_nettype wire
